[rtl/cpct_pkg.sv]
// ----------------------------------------------------------------------------
// Contact pair tracker package
// Shared types, entry layout and the contact event decision.
// ----------------------------------------------------------------------------
package cpct_pkg;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_BEGIN = 2'd1,
      EV_STAY  = 2'd2,
      EV_END   = 2'd3
   } contact_event_type;

   // One row of the pair table.
   typedef struct packed {
      logic        valid;
      logic        contact;
      logic [63:0] key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      contact_event_type ev;
      logic              next;
   } outcome_type;

   // Event and new contact bit from the stored contact bit and this check.
   function automatic outcome_type contact_outcome(input logic prev,
                                                   input logic touching,
                                                   input logic dying);
      outcome_type r;
      r.ev   = EV_NONE;
      r.next = prev;
      if (touching) begin
         if (prev && dying) begin
            r.ev   = EV_END;
            r.next = 1'b0;
         end else if (prev) begin
            r.ev = EV_STAY;
         end else if (!dying) begin
            r.ev   = EV_BEGIN;
            r.next = 1'b1;
         end
      end else if (prev) begin
         r.ev   = EV_END;
         r.next = 1'b0;
      end
      return r;
   endfunction

endpackage

[rtl/cpct_ram.sv]
// ----------------------------------------------------------------------------
// Contact pair tracker RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module cpct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/collision_pair_contact_tracker_core.sv]
// ----------------------------------------------------------------------------
// Collision pair contact tracker core
// Tracks the contact state of unordered collider pairs and reports one
// begin, stay, end or none event for every checked pair.
// ----------------------------------------------------------------------------
// After reset the block sweeps the pair table once to clear it, with
// req_stall held high throughout. Each transaction then runs in steps: an
// accept step, a hash step that issues the first read, one check step per
// probed row and a write-back step. A pair found at its home row or at an
// empty row needs a single check step; every further occupied row in the
// probe chain adds another, so a new pair checked against a completely full
// table probes all TABLE_ENTRIES rows. The single read port of the table
// means the rows are probed one at a time. The result register
// lets the next transaction be accepted while the previous result still
// waits on rsp_stall; only the write-back waits for that register to free.
// Once every row is taken, rsp_table_full reports each new pair, which is
// then treated as never having touched before.
module collision_pair_contact_tracker_core #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [31:0]                req_first_id,
   input  logic [31:0]                req_second_id,
   input  logic                       req_touching,
   input  logic                       req_dying,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cpct_pkg::contact_event_type rsp_contact_event,
   output logic                       rsp_table_full
);

   import cpct_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_PROBE = 5'b00100,
      S_CHECK = 5'b01000,
      S_WRITE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      key_ff, key_in;
   logic             touching_ff, touching_in;
   logic             dying_ff, dying_in;
   logic             slot_ok_ff, slot_ok_in;
   logic             prev_ff, prev_in;
   logic             full_ff, full_in;

   logic              rsp_valid_ff, rsp_valid_in;
   contact_event_type rsp_event_ff, rsp_event_in;
   logic              rsp_full_ff, rsp_full_in;

   logic             accept;
   logic             rsp_free;
   logic [IDX_W-1:0] fold;
   logic [IDX_W-1:0] home_idx;
   logic [IDX_W-1:0] next_idx;
   logic             last_row;
   outcome_type      outcome;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type        ram_rd_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // The home row folds the 64-bit pair key down to the index width. The
   // fold stays below twice the table depth, so one conditional subtract
   // brings it into range for depths that are not a power of two.
   always_comb begin
      fold = '0;
      for (int i = 0; i < 64; i++) begin
         fold[i % IDX_W] = fold[i % IDX_W] ^ key_ff[i];
      end
   end

   assign home_idx = ({1'b0, fold} >= (IDX_W+1)'(TABLE_ENTRIES)) ?
                     IDX_W'({1'b0, fold} - (IDX_W+1)'(TABLE_ENTRIES)) : fold;

   // Linear probing wraps at the end of the table.
   assign last_row = (idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign next_idx = last_row ? '0 : idx_ff + 1'b1;

   assign outcome = contact_outcome(prev_ff, touching_ff, dying_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      touching_in  = touching_ff;
      dying_in     = dying_ff;
      slot_ok_in   = slot_ok_ff;
      prev_in      = prev_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_event_in = rsp_event_ff;
      rsp_full_in  = rsp_full_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = '0;
      ram_rd_addr  = idx_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // Write an empty row per cycle; rows are never removed later,
            // so this is the only time the valid bits are cleared.
            ram_wr_en = 1'b1;
            idx_in    = next_idx;
            if (last_row) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               // Smaller identifier goes into the upper half of the key.
               key_in = (req_first_id < req_second_id) ?
                        {req_first_id, req_second_id} :
                        {req_second_id, req_first_id};
               touching_in = req_touching;
               dying_in    = req_dying;
               state_in    = S_PROBE;
            end
         end
         S_PROBE: begin
            ram_rd_addr = home_idx;
            idx_in      = home_idx;
            cnt_in      = '0;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            priority if (ram_rd_data.valid && ram_rd_data.key == key_ff) begin
               slot_ok_in = 1'b1;
               prev_in    = ram_rd_data.contact;
               full_in    = 1'b0;
               state_in   = S_WRITE;
            end else if (!ram_rd_data.valid) begin
               // First empty row ends the chain: the pair is new.
               slot_ok_in = 1'b1;
               prev_in    = 1'b0;
               full_in    = 1'b0;
               state_in   = S_WRITE;
            end else if (cnt_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               // Every row was probed and none matched or was free.
               slot_ok_in = 1'b0;
               prev_in    = 1'b0;
               full_in    = 1'b1;
               state_in   = S_WRITE;
            end else begin
               ram_rd_addr = next_idx;
               idx_in      = next_idx;
               cnt_in      = cnt_ff + 1'b1;
            end
         end
         S_WRITE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_event_in        = outcome.ev;
               rsp_full_in         = full_ff;
               ram_wr_en           = slot_ok_ff;
               ram_wr_data.valid   = 1'b1;
               ram_wr_data.contact = outcome.next;
               ram_wr_data.key     = key_ff;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      key_ff       <= key_in;
      touching_ff  <= touching_in;
      dying_ff     <= dying_in;
      slot_ok_ff   <= slot_ok_in;
      prev_ff      <= prev_in;
      full_ff      <= full_in;
      rsp_event_ff <= rsp_event_in;
      rsp_full_ff  <= rsp_full_in;
   end

   cpct_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_contact_event = rsp_event_ff;
   assign rsp_table_full    = rsp_full_ff;

   // A new result only appears out of the write-back step.
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_WRITE))
      else $error("result appeared outside write-back");

   // A pair that could not be stored was treated as never touching.
   a_full_no_prev: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |->
         (rsp_event_ff == EV_BEGIN || rsp_event_ff == EV_NONE))
      else $error("table full reported with stay or end event");

   // Row data is only examined right after a read was issued.
   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> $past(state_ff == S_PROBE || state_ff == S_CHECK))
      else $error("table row checked without a preceding read");

   // The table is never written while a transaction may be accepted.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> req_stall)
      else $error("table written while idle");

endmodule
